### hdl/hit_miss_ray_count_grid_unit_assert.svh
// Assertion macros used by the checker file.
`ifndef HIT_MISS_RAY_COUNT_GRID_UNIT_ASSERT_SVH
`define HIT_MISS_RAY_COUNT_GRID_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define HMRC_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define HMRC_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### hdl/hmrc_pkg.sv
`default_nettype none

package hmrc_pkg;

   // Grid geometry and counter width
   localparam int GRID_SIZE   = 1024;
   localparam int COUNT_WIDTH = 16;
   localparam int GRID_W      = $clog2(GRID_SIZE);
   localparam int CELL_TOTAL  = GRID_SIZE * GRID_SIZE;
   localparam int ADDR_W      = $clog2(CELL_TOTAL);

   // Field widths
   localparam int COORD_W = 16;
   localparam int WIDE_W  = COORD_W + 1;
   localparam int VALUE_W = 16;
   localparam int PASS_W  = 17;
   localparam int ERR_W   = WIDE_W + 3;
   localparam int ERR2_W  = ERR_W + 1;

   // Job queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // Item modes
   localparam logic MODE_RAY  = 1'b0;
   localparam logic MODE_READ = 1'b1;

   typedef logic signed [COORD_W-1:0] coord_type;
   typedef logic signed [WIDE_W-1:0]  wide_type;
   typedef logic signed [ERR_W-1:0]   err_type;
   typedef logic signed [ERR2_W-1:0]  err2_type;
   typedef logic [GRID_W-1:0]         grid_idx_type;
   typedef logic [ADDR_W-1:0]         addr_type;
   typedef logic [COUNT_WIDTH-1:0]    count_type;
   typedef logic [VALUE_W-1:0]        value_type;
   typedef logic [PASS_W-1:0]         pass_type;

   typedef struct packed {
      logic      mode;
      coord_type robot_x;
      coord_type robot_y;
      coord_type end_x;
      coord_type end_y;
   } req_type;

   typedef struct packed {
      value_type hit_value;
      value_type miss_value;
      logic      cell_on_grid;
      pass_type  cells_passed;
   } rsp_type;

   // Classified item handed from front to back
   typedef struct packed {
      logic     mode;
      logic     on_grid;
      addr_type end_addr;
      wide_type end_x;
      wide_type end_y;
      logic     steep;
      wide_type a_start;
      wide_type a_end;
      wide_type b_start;
      wide_type da;
      wide_type db;
      logic     bstep_neg;
   } job_type;

   typedef struct packed {
      logic clear_busy;
   } back_status_type;

   function automatic logic on_grid(input wide_type x, input wide_type y);
      return !x[WIDE_W-1] && (x < wide_type'(GRID_SIZE)) &&
             !y[WIDE_W-1] && (y < wide_type'(GRID_SIZE));
   endfunction

   function automatic addr_type cell_index(input grid_idx_type x, input grid_idx_type y);
      return addr_type'(x) * addr_type'(GRID_SIZE) + addr_type'(y);
   endfunction

   function automatic wide_type abs_wide(input wide_type v);
      return v[WIDE_W-1] ? -v : v;
   endfunction

   function automatic count_type sat_inc(input count_type c);
      return (c == '1) ? c : c + count_type'(1);
   endfunction

   function automatic value_type to_value(input count_type c);
      logic [COUNT_WIDTH+VALUE_W-1:0] ext;
      ext = {{VALUE_W{1'b0}}, c};
      return ext[VALUE_W-1:0];
   endfunction

endpackage

`default_nettype wire

### hdl/hmrc_queue.sv
`default_nettype none

module hmrc_queue (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire hmrc_pkg::job_type push_job,
   output logic                  full,
   input  wire logic             pop,
   output hmrc_pkg::job_type     head_job,
   output logic                  empty
);

   hmrc_pkg::job_type                 entry_ff [hmrc_pkg::QUEUE_DEPTH];
   logic [hmrc_pkg::QPTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [hmrc_pkg::QPTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [hmrc_pkg::QCNT_W-1:0]       count_ff, count_in;

   assign full     = (count_ff == hmrc_pkg::QCNT_W'(hmrc_pkg::QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign head_job = entry_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == hmrc_pkg::QPTR_W'(hmrc_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + hmrc_pkg::QPTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == hmrc_pkg::QPTR_W'(hmrc_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + hmrc_pkg::QPTR_W'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + hmrc_pkg::QCNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - hmrc_pkg::QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

`default_nettype wire

### hdl/hmrc_front.sv
`default_nettype none

module hmrc_front (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_stall,
   input  wire hmrc_pkg::req_type         req_data,
   input  wire hmrc_pkg::back_status_type back_status,
   input  wire logic                      q_full,
   output logic                           q_push,
   output hmrc_pkg::job_type              q_job
);

   localparam logic [1:0] F_IDLE = 2'd0;
   localparam logic [1:0] F_CALC = 2'd1;
   localparam logic [1:0] F_SWAP = 2'd2;
   localparam logic [1:0] F_PUSH = 2'd3;

   logic [1:0]         state_ff, state_in;
   hmrc_pkg::req_type  item_ff, item_in;
   logic               steep_ff, steep_in;
   hmrc_pkg::job_type  job_ff, job_in;

   hmrc_pkg::wide_type rx, ry, ex, ey;
   hmrc_pkg::wide_type a0, b0, a1, b1;
   logic               swap;

   assign req_stall = back_status.clear_busy || (state_ff != F_IDLE);
   assign q_job     = job_ff;

   // sign-extended coordinates of the held item
   assign rx = hmrc_pkg::wide_type'(item_ff.robot_x);
   assign ry = hmrc_pkg::wide_type'(item_ff.robot_y);
   assign ex = hmrc_pkg::wide_type'(item_ff.end_x);
   assign ey = hmrc_pkg::wide_type'(item_ff.end_y);

   // major axis selection, then order the ends along it
   assign a0   = steep_ff ? ry : rx;
   assign b0   = steep_ff ? rx : ry;
   assign a1   = steep_ff ? ey : ex;
   assign b1   = steep_ff ? ex : ey;
   assign swap = (a0 > a1);

   always_comb begin
      state_in = state_ff;
      item_in  = item_ff;
      steep_in = steep_ff;
      job_in   = job_ff;
      q_push   = 1'b0;
      unique case (state_ff)
         F_IDLE: begin
            if (req_valid && !req_stall) begin
               item_in  = req_data;
               state_in = F_CALC;
            end
         end
         F_CALC: begin
            steep_in = hmrc_pkg::abs_wide(ey - ry) > hmrc_pkg::abs_wide(ex - rx);
            state_in = F_SWAP;
         end
         F_SWAP: begin
            job_in.mode      = item_ff.mode;
            job_in.on_grid   = hmrc_pkg::on_grid(ex, ey);
            job_in.end_addr  = hmrc_pkg::cell_index(
                                  item_ff.end_x[hmrc_pkg::GRID_W-1:0],
                                  item_ff.end_y[hmrc_pkg::GRID_W-1:0]);
            job_in.end_x     = ex;
            job_in.end_y     = ey;
            job_in.steep     = steep_ff;
            job_in.a_start   = swap ? a1 : a0;
            job_in.a_end     = swap ? a0 : a1;
            job_in.b_start   = swap ? b1 : b0;
            job_in.da        = hmrc_pkg::abs_wide(a1 - a0);
            job_in.db        = hmrc_pkg::abs_wide(b1 - b0);
            // step direction along the minor axis, walking from the lower major end
            job_in.bstep_neg = swap ? !(b1 < b0) : !(b0 < b1);
            state_in         = F_PUSH;
         end
         F_PUSH: begin
            if (!q_full) begin
               q_push   = 1'b1;
               state_in = F_IDLE;
            end
         end
         default: begin
            state_in = F_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff  <= item_in;
      steep_ff <= steep_in;
      job_ff   <= job_in;
   end

endmodule

`default_nettype wire

### hdl/hmrc_back.sv
`default_nettype none

module hmrc_back (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 q_empty,
   input  wire hmrc_pkg::job_type    q_job,
   output logic                      q_pop,
   output hmrc_pkg::back_status_type back_status,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output hmrc_pkg::rsp_type         rsp_data
);

   localparam logic [2:0] B_CLEAR    = 3'd0;
   localparam logic [2:0] B_IDLE     = 3'd1;
   localparam logic [2:0] B_RD_ISSUE = 3'd2;
   localparam logic [2:0] B_RD_DATA  = 3'd3;
   localparam logic [2:0] B_HIT_RD   = 3'd4;
   localparam logic [2:0] B_HIT_WR   = 3'd5;
   localparam logic [2:0] B_WALK     = 3'd6;
   localparam logic [2:0] B_FINISH   = 3'd7;

   // counter memories
   hmrc_pkg::count_type hit_mem  [hmrc_pkg::CELL_TOTAL];
   hmrc_pkg::count_type miss_mem [hmrc_pkg::CELL_TOTAL];
   hmrc_pkg::count_type hit_rd_ff, miss_rd_ff;

   logic                hit_we, hit_re, miss_we, miss_re;
   hmrc_pkg::addr_type  hit_waddr, hit_raddr, miss_waddr, miss_raddr;
   hmrc_pkg::count_type hit_wdata, miss_wdata;

   logic [2:0]             state_ff, state_in;
   hmrc_pkg::addr_type     clear_addr_ff, clear_addr_in;
   hmrc_pkg::job_type      cur_ff, cur_in;
   hmrc_pkg::wide_type     a_ff, a_in;
   hmrc_pkg::wide_type     b_ff, b_in;
   hmrc_pkg::err_type      err_ff, err_in;
   hmrc_pkg::pass_type     passed_ff, passed_in;
   logic                   pt_valid_ff, pt_valid_in;
   hmrc_pkg::grid_idx_type pt_x_ff, pt_x_in;
   hmrc_pkg::grid_idx_type pt_y_ff, pt_y_in;
   logic                   wr_valid_ff, wr_valid_in;
   hmrc_pkg::addr_type     wr_addr_ff, wr_addr_in;
   hmrc_pkg::rsp_type      res_ff, res_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   hmrc_pkg::rsp_type      rsp_ff, rsp_in;

   hmrc_pkg::wide_type px, py;
   hmrc_pkg::err_type  err_sum;
   hmrc_pkg::addr_type pt_addr;
   logic               is_end, walk_more, step_b, out_free;

   assign back_status.clear_busy = (state_ff == B_CLEAR);
   assign rsp_valid              = rsp_valid_ff;
   assign rsp_data               = rsp_ff;

   // current line cell and error term of the walk
   assign px        = cur_ff.steep ? b_ff : a_ff;
   assign py        = cur_ff.steep ? a_ff : b_ff;
   assign is_end    = (px == cur_ff.end_x) && (py == cur_ff.end_y);
   assign walk_more = (a_ff <= cur_ff.a_end);
   assign err_sum   = err_ff + hmrc_pkg::err_type'(cur_ff.db);
   assign step_b    = $signed({err_sum, 1'b0}) >= hmrc_pkg::err2_type'(cur_ff.da);
   assign pt_addr   = hmrc_pkg::cell_index(pt_x_ff, pt_y_ff);
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in      = state_ff;
      clear_addr_in = clear_addr_ff;
      cur_in        = cur_ff;
      a_in          = a_ff;
      b_in          = b_ff;
      err_in        = err_ff;
      passed_in     = passed_ff;
      pt_valid_in   = 1'b0;
      pt_x_in       = pt_x_ff;
      pt_y_in       = pt_y_ff;
      res_in        = res_ff;
      rsp_in        = rsp_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      q_pop         = 1'b0;
      hit_we        = 1'b0;
      hit_re        = 1'b0;
      hit_waddr     = cur_ff.end_addr;
      hit_raddr     = cur_ff.end_addr;
      hit_wdata     = hmrc_pkg::sat_inc(hit_rd_ff);

      // miss read-modify-write pipeline: read the cell, write the increment in the next cycle
      miss_re     = pt_valid_ff;
      miss_raddr  = pt_valid_ff ? pt_addr : cur_ff.end_addr;
      wr_valid_in = pt_valid_ff;
      wr_addr_in  = pt_addr;
      miss_we     = wr_valid_ff;
      miss_waddr  = wr_addr_ff;
      miss_wdata  = hmrc_pkg::sat_inc(miss_rd_ff);

      unique case (state_ff)
         B_CLEAR: begin
            hit_we        = 1'b1;
            hit_waddr     = clear_addr_ff;
            hit_wdata     = '0;
            miss_we       = 1'b1;
            miss_waddr    = clear_addr_ff;
            miss_wdata    = '0;
            clear_addr_in = clear_addr_ff + hmrc_pkg::addr_type'(1);
            if (clear_addr_ff == hmrc_pkg::addr_type'(hmrc_pkg::CELL_TOTAL - 1)) begin
               state_in = B_IDLE;
            end
         end
         B_IDLE: begin
            if (!q_empty) begin
               q_pop    = 1'b1;
               cur_in   = q_job;
               state_in = (q_job.mode == hmrc_pkg::MODE_READ) ? B_RD_ISSUE : B_HIT_RD;
            end
         end
         B_RD_ISSUE: begin
            hit_re   = 1'b1;
            miss_re  = 1'b1;
            state_in = B_RD_DATA;
         end
         B_RD_DATA: begin
            res_in.hit_value    = cur_ff.on_grid ? hmrc_pkg::to_value(hit_rd_ff) : '0;
            res_in.miss_value   = cur_ff.on_grid ? hmrc_pkg::to_value(miss_rd_ff) : '0;
            res_in.cell_on_grid = cur_ff.on_grid;
            res_in.cells_passed = '0;
            state_in            = B_FINISH;
         end
         B_HIT_RD: begin
            hit_re    = 1'b1;
            a_in      = cur_ff.a_start;
            b_in      = cur_ff.b_start;
            err_in    = '0;
            passed_in = '0;
            state_in  = B_HIT_WR;
         end
         B_HIT_WR: begin
            hit_we   = cur_ff.on_grid;
            state_in = B_WALK;
         end
         B_WALK: begin
            if (walk_more) begin
               // one line cell per cycle along the major axis
               a_in = a_ff + hmrc_pkg::wide_type'(1);
               if (step_b) begin
                  b_in   = cur_ff.bstep_neg ? b_ff - hmrc_pkg::wide_type'(1) :
                                              b_ff + hmrc_pkg::wide_type'(1);
                  err_in = err_sum - hmrc_pkg::err_type'(cur_ff.da);
               end else begin
                  err_in = err_sum;
               end
               pt_valid_in = !is_end && hmrc_pkg::on_grid(px, py);
               pt_x_in     = px[hmrc_pkg::GRID_W-1:0];
               pt_y_in     = py[hmrc_pkg::GRID_W-1:0];
               if (pt_valid_in) begin
                  passed_in = passed_ff + hmrc_pkg::pass_type'(1);
               end
            end else begin
               res_in.hit_value    = '0;
               res_in.miss_value   = '0;
               res_in.cell_on_grid = cur_ff.on_grid;
               res_in.cells_passed = passed_ff;
               state_in            = B_FINISH;
            end
         end
         B_FINISH: begin
            // wait for pending miss writes and a free output, then hand the result to the output
            if (!pt_valid_ff && !wr_valid_ff && out_free) begin
               rsp_valid_in = 1'b1;
               rsp_in       = res_ff;
               state_in     = B_IDLE;
            end
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= B_CLEAR;
         clear_addr_ff <= '0;
         pt_valid_ff   <= 1'b0;
         wr_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clear_addr_ff <= clear_addr_in;
         pt_valid_ff   <= pt_valid_in;
         wr_valid_ff   <= wr_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff     <= cur_in;
      a_ff       <= a_in;
      b_ff       <= b_in;
      err_ff     <= err_in;
      passed_ff  <= passed_in;
      pt_x_ff    <= pt_x_in;
      pt_y_ff    <= pt_y_in;
      wr_addr_ff <= wr_addr_in;
      res_ff     <= res_in;
      rsp_ff     <= rsp_in;
   end

   // hit counter memory
   always_ff @(posedge clock) begin
      if (hit_we) begin
         hit_mem[hit_waddr] <= hit_wdata;
      end
      if (hit_re) begin
         hit_rd_ff <= hit_mem[hit_raddr];
      end
   end

   // miss counter memory
   always_ff @(posedge clock) begin
      if (miss_we) begin
         miss_mem[miss_waddr] <= miss_wdata;
      end
      if (miss_re) begin
         miss_rd_ff <= miss_mem[miss_raddr];
      end
   end

endmodule

`default_nettype wire

### hdl/hit_miss_ray_count_grid_unit.sv
// Channel   Handshake                Payload
// req       req_valid / req_stall    req_data  (hmrc_pkg::req_type)
// rsp       rsp_valid / rsp_stall    rsp_data  (hmrc_pkg::rsp_type)
//
// Read item: front (F_CALC, F_SWAP, F_PUSH), queue, back (B_RD_ISSUE, B_RD_DATA, B_FINISH).
// Ray item: B_HIT_RD, B_HIT_WR, the walk over the major-axis span, then B_FINISH waits
// for the last miss write; the walk makes one line cell per cycle through the miss memory.
// Reset: a clearing pass over all CELL_TOTAL (1048576) cells zeroes both counter
// memories; req_stall stays high throughout it.
// The front takes the next item while the back walks; rsp_stall holds the result.
`default_nettype none

module hit_miss_ray_count_grid_unit (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire hmrc_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output hmrc_pkg::rsp_type      rsp_data
);

   hmrc_pkg::back_status_type back_status;
   hmrc_pkg::job_type         push_job, head_job;
   logic                      q_push, q_pop, q_full, q_empty;

   // classify and set up the line
   hmrc_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .back_status (back_status),
      .q_full      (q_full),
      .q_push      (q_push),
      .q_job       (push_job)
   );

   // job queue between front and back
   hmrc_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_job (push_job),
      .full     (q_full),
      .pop      (q_pop),
      .head_job (head_job),
      .empty    (q_empty)
   );

   // counter memories, line walk and result register
   hmrc_back u_back (
      .clock       (clock),
      .reset       (reset),
      .q_empty     (q_empty),
      .q_job       (head_job),
      .q_pop       (q_pop),
      .back_status (back_status),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data)
   );

endmodule

`default_nettype wire

### hdl/hmrc_checker.sv
`default_nettype none
`include "hit_miss_ray_count_grid_unit_assert.svh"

module hmrc_checker (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              req_stall,
   input wire logic              rsp_valid,
   input wire logic              rsp_stall,
   input wire hmrc_pkg::rsp_type rsp_data
);

   // a stalled result holds
   `HMRC_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data), "stalled result changed")

   // off-grid cells never report counter values
   `HMRC_ASSERT_IMP(a_off_grid_zero, clock, reset, rsp_valid && !rsp_data.cell_on_grid, rsp_data.hit_value == '0 && rsp_data.miss_value == '0, "off-grid result carries counter values")

   // counter values come only from reads, which walk no line
   `HMRC_ASSERT_IMP(a_read_no_walk, clock, reset, rsp_valid && (rsp_data.hit_value != '0 || rsp_data.miss_value != '0), rsp_data.cells_passed == '0, "read result with walked cells")

   // right after reset the counters are being cleared and no result is shown
   `HMRC_ASSERT_IMP(a_reset_clear, clock, reset, $past(reset), req_stall && !rsp_valid, "input open or result shown during clearing")

endmodule

bind hit_miss_ray_count_grid_unit hmrc_checker u_checker (.*);

`default_nettype wire
